FILE: rtl/srng_pkg.sv
// srng_pkg: shared constants for the shortest-route-to-goal block
// field widths of the request and response channels, operation codes, parameter defaults
// no dependencies

package srng_pkg;

   localparam int OP_FW     = 2;
   localparam int NODE_FW   = 6;
   localparam int SLOT_FW   = 3;
   localparam int WEIGHT_FW = 16;

   localparam logic [OP_FW-1:0] OP_EDGE  = 2'd0;
   localparam logic [OP_FW-1:0] OP_GOAL  = 2'd1;
   localparam logic [OP_FW-1:0] OP_ROUTE = 2'd2;

   localparam int DEF_NODES       = 64;
   localparam int DEF_DEGREE      = 8;
   localparam int DEF_WEIGHT_BITS = 16;
   localparam int DEF_DIST_BITS   = 24;

endpackage

FILE: rtl/srng_if.sv
// srng_req_if, srng_rsp_if: valid/ready channels of the shortest-route-to-goal block
// depends on srng_pkg for the field widths

interface srng_req_if;
   import srng_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [OP_FW-1:0]     operation;
   logic [NODE_FW-1:0]   node;
   logic [SLOT_FW-1:0]   slot;
   logic [NODE_FW-1:0]   neighbour;
   logic [WEIGHT_FW-1:0] weight;
   logic                 flag;

   modport source (output valid, operation, node, slot, neighbour, weight, flag,
                   input ready);
   modport sink   (input valid, operation, node, slot, neighbour, weight, flag,
                   output ready);
endinterface

interface srng_rsp_if;
   import srng_pkg::*;
   logic               valid;
   logic               ready;
   logic               found;
   logic [NODE_FW-1:0] edge_source;
   logic [SLOT_FW-1:0] edge_slot;
   logic               last;

   modport source (output valid, found, edge_source, edge_slot, last, input ready);
   modport sink   (input valid, found, edge_source, edge_slot, last, output ready);
endinterface

FILE: rtl/shortest_route_to_nearest_goal.sv
// Route search over a stored directed graph: nearest marked goal from a start node.
// Edge writes, goal marks and route queries arrive on one request channel; route
// steps leave on the response channel. After reset the edge store is swept clear,
// one entry a cycle; no request is taken during the sweep. A route query runs a
// search where every settled node costs one pass over the distance memory to find
// the nearest open node, plus a relaxation of each edge slot through the edge and
// distance memories. The route is then traced back through the parent memory into
// the route buffer and sent one response per edge, each held until it is taken.
// One request is worked on at a time.
// depends on srng_pkg and the channel interfaces in srng_if

module shortest_route_to_nearest_goal #(
   parameter int NODES       = srng_pkg::DEF_NODES,
   parameter int DEGREE      = srng_pkg::DEF_DEGREE,
   parameter int WEIGHT_BITS = srng_pkg::DEF_WEIGHT_BITS,
   parameter int DIST_BITS   = srng_pkg::DEF_DIST_BITS
) (
   input logic         clock,
   input logic         reset,
   srng_req_if.sink    req_chan,
   srng_rsp_if.source  rsp_chan
);
   import srng_pkg::*;

   localparam int NODE_W  = $clog2(NODES);
   localparam int SLOT_W  = (DEGREE > 1) ? $clog2(DEGREE) : 1;
   localparam int ENTRIES = NODES * DEGREE;
   localparam int EADDR_W = $clog2(ENTRIES);
   localparam int P_W     = NODE_W + SLOT_W;
   localparam int SUM_W   = ((DIST_BITS > WEIGHT_BITS) ? DIST_BITS : WEIGHT_BITS) + 1;
   localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};

   localparam logic [3:0] ST_CLEAR = 4'd0;
   localparam logic [3:0] ST_IDLE  = 4'd1;
   localparam logic [3:0] ST_SCAN  = 4'd2;
   localparam logic [3:0] ST_PICK  = 4'd3;
   localparam logic [3:0] ST_ERD   = 4'd4;
   localparam logic [3:0] ST_ECHK  = 4'd5;
   localparam logic [3:0] ST_EUPD  = 4'd6;
   localparam logic [3:0] ST_TRD   = 4'd7;
   localparam logic [3:0] ST_TWR   = 4'd8;
   localparam logic [3:0] ST_ORD   = 4'd9;
   localparam logic [3:0] ST_OLOAD = 4'd10;
   localparam logic [3:0] ST_OWAIT = 4'd11;

   typedef struct packed {
      logic                   vld;
      logic [NODE_FW-1:0]     nbr;
      logic [WEIGHT_BITS-1:0] wt;
   } edge_type;

   // memories
   edge_type               edge_mem   [ENTRIES];
   logic [DIST_BITS-1:0]   dist_mem   [NODES];
   logic [P_W-1:0]         parent_mem [NODES];
   logic [P_W-1:0]         route_mem  [NODES];

   logic                   e_we;
   logic [EADDR_W-1:0]     e_waddr, e_raddr;
   edge_type               e_wdata, e_rdata_ff;
   logic                   d_we;
   logic [NODE_W-1:0]      d_waddr, d_raddr;
   logic [DIST_BITS-1:0]   d_wdata, d_rdata_ff;
   logic                   p_we;
   logic [NODE_W-1:0]      p_waddr, p_raddr;
   logic [P_W-1:0]         p_wdata, p_rdata_ff;
   logic                   r_we;
   logic [NODE_W-1:0]      r_waddr, r_raddr;
   logic [P_W-1:0]         r_wdata, r_rdata_ff;

   // control and datapath registers
   logic [3:0]             state_ff, state_in;
   logic [EADDR_W-1:0]     clr_ff, clr_in;
   logic [NODES-1:0]       goal_ff, goal_in;
   logic [NODES-1:0]       reached_ff, reached_in;
   logic [NODES-1:0]       settled_ff, settled_in;
   logic [NODE_W:0]        idx_ff, idx_in;
   logic                   cmp_vld_ff, cmp_vld_in;
   logic [NODE_W-1:0]      cmp_idx_ff, cmp_idx_in;
   logic                   any_ff, any_in;
   logic [NODE_W-1:0]      u_ff, u_in;
   logic [DIST_BITS-1:0]   bd_ff, bd_in;
   logic [SLOT_W:0]        slot_ff, slot_in;
   logic [NODE_W-1:0]      v_ff, v_in;
   logic [DIST_BITS-1:0]   nd_ff, nd_in;
   logic [NODE_W-1:0]      start_ff, start_in;
   logic [NODE_W-1:0]      cur_ff, cur_in;
   logic [NODE_W-1:0]      cnt_ff, cnt_in;
   logic [NODE_W-1:0]      oi_ff, oi_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   found_ff, found_in;
   logic [NODE_FW-1:0]     src_ff, src_in;
   logic [SLOT_FW-1:0]     oslot_ff, oslot_in;
   logic                   last_ff, last_in;

   logic [31:0]            node_x, wt_x, nbr_x, psrc_x, pslot_x, rsrc_x, rslot_x;
   logic [NODE_W-1:0]      node_i, nbr_i, psrc_i;
   logic                   node_ok, slot_ok;
   logic [SUM_W-1:0]       sum;
   logic [DIST_BITS-1:0]   nd_sat;

   assign node_x  = 32'(req_chan.node);
   assign node_i  = node_x[NODE_W-1:0];
   assign node_ok = node_x < NODES;
   assign slot_ok = 32'(req_chan.slot) < DEGREE;
   assign wt_x    = 32'(req_chan.weight);
   assign nbr_x   = 32'(e_rdata_ff.nbr);
   assign nbr_i   = nbr_x[NODE_W-1:0];
   assign psrc_x  = 32'(p_rdata_ff[P_W-1:SLOT_W]);
   assign psrc_i  = psrc_x[NODE_W-1:0];
   assign rsrc_x  = 32'(r_rdata_ff[P_W-1:SLOT_W]);
   assign rslot_x = 32'(r_rdata_ff[SLOT_W-1:0]);
   assign pslot_x = 32'(slot_ff[SLOT_W-1:0]);

   // the distance adder: saturating distance through the settled node
   assign sum    = SUM_W'(bd_ff) + SUM_W'(e_rdata_ff.wt);
   assign nd_sat = (sum > SUM_W'(DIST_MAX)) ? DIST_MAX : sum[DIST_BITS-1:0];

   assign req_chan.ready       = (state_ff == ST_IDLE);
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.found       = found_ff;
   assign rsp_chan.edge_source = src_ff;
   assign rsp_chan.edge_slot   = oslot_ff;
   assign rsp_chan.last        = last_ff;

   always_ff @(posedge clock) begin
      if (e_we) begin
         edge_mem[e_waddr] <= e_wdata;
      end
      e_rdata_ff <= edge_mem[e_raddr];
   end

   always_ff @(posedge clock) begin
      if (d_we) begin
         dist_mem[d_waddr] <= d_wdata;
      end
      d_rdata_ff <= dist_mem[d_raddr];
   end

   always_ff @(posedge clock) begin
      if (p_we) begin
         parent_mem[p_waddr] <= p_wdata;
      end
      p_rdata_ff <= parent_mem[p_raddr];
   end

   always_ff @(posedge clock) begin
      if (r_we) begin
         route_mem[r_waddr] <= r_wdata;
      end
      r_rdata_ff <= route_mem[r_raddr];
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      goal_in      = goal_ff;
      reached_in   = reached_ff;
      settled_in   = settled_ff;
      idx_in       = idx_ff;
      cmp_vld_in   = 1'b0;
      cmp_idx_in   = cmp_idx_ff;
      any_in       = any_ff;
      u_in         = u_ff;
      bd_in        = bd_ff;
      slot_in      = slot_ff;
      v_in         = v_ff;
      nd_in        = nd_ff;
      start_in     = start_ff;
      cur_in       = cur_ff;
      cnt_in       = cnt_ff;
      oi_in        = oi_ff;
      rsp_valid_in = rsp_valid_ff;
      found_in     = found_ff;
      src_in       = src_ff;
      oslot_in     = oslot_ff;
      last_in      = last_ff;

      e_we    = 1'b0;
      e_waddr = EADDR_W'(32'(node_i) * DEGREE + 32'(req_chan.slot));
      e_wdata = '{vld: req_chan.flag, nbr: req_chan.neighbour,
                  wt: wt_x[WEIGHT_BITS-1:0]};
      e_raddr = EADDR_W'(32'(u_ff) * DEGREE + pslot_x);
      d_we    = 1'b0;
      d_waddr = v_ff;
      d_wdata = nd_ff;
      d_raddr = idx_ff[NODE_W-1:0];
      p_we    = 1'b0;
      p_waddr = v_ff;
      p_wdata = {u_ff, slot_ff[SLOT_W-1:0]};
      p_raddr = cur_ff;
      r_we    = 1'b0;
      r_waddr = cnt_ff;
      r_wdata = p_rdata_ff;
      r_raddr = oi_ff;

      case (state_ff)
         ST_CLEAR: begin
            e_we    = 1'b1;
            e_waddr = clr_ff;
            e_wdata = '0;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == EADDR_W'(ENTRIES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_chan.valid) begin
               case (req_chan.operation)
                  OP_EDGE: begin
                     e_we = node_ok && slot_ok;
                  end
                  OP_GOAL: begin
                     if (node_ok) begin
                        goal_in[node_i] = req_chan.flag;
                     end
                  end
                  OP_ROUTE: begin
                     if (node_ok) begin
                        start_in         = node_i;
                        reached_in       = '0;
                        reached_in[node_i] = 1'b1;
                        settled_in       = '0;
                        d_we             = 1'b1;
                        d_waddr          = node_i;
                        d_wdata          = '0;
                        p_we             = 1'b1;
                        p_waddr          = node_i;
                        p_wdata          = {node_i, {SLOT_W{1'b0}}};
                        idx_in           = '0;
                        any_in           = 1'b0;
                        state_in         = ST_SCAN;
                     end else begin
                        rsp_valid_in = 1'b1;
                        found_in     = 1'b0;
                        src_in       = '0;
                        oslot_in     = '0;
                        last_in      = 1'b1;
                        state_in     = ST_OWAIT;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            // the compare works on the distance read issued in the cycle before
            if (cmp_vld_ff && reached_ff[cmp_idx_ff] && !settled_ff[cmp_idx_ff] &&
                (!any_ff || d_rdata_ff <= bd_ff)) begin
               any_in = 1'b1;
               u_in   = cmp_idx_ff;
               bd_in  = d_rdata_ff;
            end
            if (idx_ff == (NODE_W+1)'(NODES)) begin
               state_in = ST_PICK;
            end else begin
               cmp_vld_in = 1'b1;
               cmp_idx_in = idx_ff[NODE_W-1:0];
               idx_in     = idx_ff + 1'b1;
            end
         end
         ST_PICK: begin
            if (!any_ff) begin
               rsp_valid_in = 1'b1;
               found_in     = 1'b0;
               src_in       = '0;
               oslot_in     = '0;
               last_in      = 1'b1;
               state_in     = ST_OWAIT;
            end else begin
               settled_in[u_ff] = 1'b1;
               if (goal_ff[u_ff]) begin
                  cur_in   = u_ff;
                  cnt_in   = '0;
                  state_in = (u_ff == start_ff) ? ST_IDLE : ST_TRD;
               end else begin
                  slot_in  = '0;
                  state_in = ST_ERD;
               end
            end
         end
         ST_ERD: begin
            if (slot_ff == (SLOT_W+1)'(DEGREE)) begin
               idx_in   = '0;
               any_in   = 1'b0;
               state_in = ST_SCAN;
            end else begin
               state_in = ST_ECHK;
            end
         end
         ST_ECHK: begin
            d_raddr = nbr_i;
            v_in    = nbr_i;
            nd_in   = nd_sat;
            if (e_rdata_ff.vld && nbr_x < NODES && !settled_ff[nbr_i]) begin
               state_in = ST_EUPD;
            end else begin
               slot_in  = slot_ff + 1'b1;
               state_in = ST_ERD;
            end
         end
         ST_EUPD: begin
            if (!reached_ff[v_ff] || d_rdata_ff > nd_ff) begin
               d_we             = 1'b1;
               p_we             = 1'b1;
               reached_in[v_ff] = 1'b1;
            end
            slot_in  = slot_ff + 1'b1;
            state_in = ST_ERD;
         end
         ST_TRD: begin
            state_in = ST_TWR;
         end
         ST_TWR: begin
            // route buffer fills from the goal back toward the start
            r_we   = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            cur_in = psrc_i;
            if (psrc_i == start_ff) begin
               oi_in    = cnt_ff;
               state_in = ST_ORD;
            end else begin
               state_in = ST_TRD;
            end
         end
         ST_ORD: begin
            state_in = ST_OLOAD;
         end
         ST_OLOAD: begin
            rsp_valid_in = 1'b1;
            found_in     = 1'b1;
            src_in       = rsrc_x[NODE_FW-1:0];
            oslot_in     = rslot_x[SLOT_FW-1:0];
            last_in      = (oi_ff == '0);
            state_in     = ST_OWAIT;
         end
         ST_OWAIT: begin
            if (rsp_chan.ready) begin
               rsp_valid_in = 1'b0;
               if (last_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  oi_in    = oi_ff - 1'b1;
                  state_in = ST_ORD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         goal_ff      <= '0;
         reached_ff   <= '0;
         settled_ff   <= '0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         goal_ff      <= goal_in;
         reached_ff   <= reached_in;
         settled_ff   <= settled_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      cmp_idx_ff <= cmp_idx_in;
      any_ff     <= any_in;
      u_ff       <= u_in;
      bd_ff      <= bd_in;
      slot_ff    <= slot_in;
      v_ff       <= v_in;
      nd_ff      <= nd_in;
      start_ff   <= start_in;
      cur_ff     <= cur_in;
      cnt_ff     <= cnt_in;
      oi_ff      <= oi_in;
      found_ff   <= found_in;
      src_ff     <= src_in;
      oslot_ff   <= oslot_in;
      last_ff    <= last_in;
   end

`ifndef SYNTHESIS
   a_no_req_during_rsp: assert property (@(posedge clock) disable iff (reset)
      !(req_chan.ready && rsp_chan.valid))
      else $error("request taken while a response is pending");

   a_settled_are_reached: assert property (@(posedge clock) disable iff (reset)
      (settled_ff & ~reached_ff) == '0)
      else $error("node settled without being reached");

   a_last_ends_query: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.ready && rsp_chan.last) |=> state_ff == ST_IDLE)
      else $error("final response did not return to idle");

   a_miss_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.found) |-> rsp_chan.last)
      else $error("not-found response without last");
`endif

endmodule
